// ----- design/mbps_pkg.sv -----
package mbps_pkg;

   // Operation carried by each request word.
   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_STREAM  = 2'd1,
      OP_RESTART = 2'd2
   } opcode_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_BASE_ADDRESS = 2'd0,
      CSR_START_OFFSET = 2'd1,
      CSR_PATTERN_LEN  = 2'd2
   } csr_index_type;

   localparam int unsigned POS_W  = 32;
   localparam int unsigned ADDR_W = 64;

   // Commands from the top level to the pattern/window datapath.
   typedef struct packed {
      logic       load;
      logic       shift;
      logic       restart;
      logic [6:0] entry_index;
      logic [7:0] pattern_byte;
      logic       care;
      logic [7:0] data_byte;
   } ctl_type;

endpackage

// ----- design/mbps_req_if.sv -----
interface mbps_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [6:0] entry_index;
   logic [7:0] pattern_byte;
   logic       care;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (
      output valid, opcode, entry_index, pattern_byte, care, data_byte, last_byte,
      input  ready
   );
   modport sink (
      input  valid, opcode, entry_index, pattern_byte, care, data_byte, last_byte,
      output ready
   );
endinterface

// ----- design/mbps_rsp_if.sv -----
interface mbps_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [31:0] match_offset;
   logic [63:0] match_address;

   modport source (
      output valid, found, match_offset, match_address,
      input  ready
   );
   modport sink (
      input  valid, found, match_offset, match_address,
      output ready
   );
endinterface

// ----- design/mbps_csr_if.sv -----
interface mbps_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] wdata;

   modport source (
      output valid, index, wdata,
      input  ready
   );
   modport sink (
      input  valid, index, wdata,
      output ready
   );
endinterface

// ----- design/masked_byte_pattern_search_core.sv -----
// A request word is held first in the input register, and its response word
// then in the response register until the response side takes it.
// Throughput: one request word per cycle, stream bytes included, as long as
// the response side takes results; the parallel window compare sets this.
// Reset (synchronous, active high) clears the pattern to all wildcards, the
// window, the position and the registers (pattern length 1).
module masked_byte_pattern_search_core #(
   parameter int unsigned PATTERN_MAX = 128
) (
   input  logic       clock,
   input  logic       reset,
   mbps_req_if.sink   req_ch,
   mbps_rsp_if.source rsp_ch,
   mbps_csr_if.sink   csr_ch
);

   localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int unsigned POS_W = mbps_pkg::POS_W;

   // Configuration registers. The pattern length is clamped when written, so
   // the datapath only ever sees a length between 1 and PATTERN_MAX.
   logic [mbps_pkg::ADDR_W-1:0] base_ff, base_in;
   logic [POS_W-1:0]            start_ff, start_in;
   logic [LEN_W-1:0]            len_ff, len_in;
   logic [7:0]                  len_wdata;

   // Input register: one request word waiting to be processed.
   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_op_ff, s1_op_in;
   logic [6:0] s1_idx_ff, s1_idx_in;
   logic [7:0] s1_pbyte_ff, s1_pbyte_in;
   logic       s1_care_ff, s1_care_in;
   logic [7:0] s1_data_ff, s1_data_in;
   logic       s1_last_ff, s1_last_in;

   // Scan state.
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             done_ff, done_in;

   // Response register.
   logic                        out_valid_ff, out_valid_in;
   logic                        out_found_ff, out_found_in;
   logic [POS_W-1:0]            out_offset_ff, out_offset_in;
   logic [mbps_pkg::ADDR_W-1:0] out_addr_ff, out_addr_in;

   logic              req_accept;
   logic              stream_item;
   logic              saturated;
   logic [POS_W-1:0]  taken;
   logic [POS_W-1:0]  len_wide;
   logic [POS_W-1:0]  start_pos;
   logic              hit;
   logic              not_found;
   logic              produce;
   logic              out_free;
   logic              advance;
   logic              window_match;
   mbps_pkg::ctl_type ctl;

   // Configuration writes are always taken.
   assign csr_ch.ready = 1'b1;
   assign len_wdata    = csr_ch.wdata[7:0];

   always_comb begin
      base_in  = base_ff;
      start_in = start_ff;
      len_in   = len_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            mbps_pkg::CSR_BASE_ADDRESS: begin
               base_in = csr_ch.wdata;
            end
            mbps_pkg::CSR_START_OFFSET: begin
               start_in = csr_ch.wdata[POS_W-1:0];
            end
            mbps_pkg::CSR_PATTERN_LEN: begin
               // Zero acts as one entry; anything past the storage acts as full.
               if (len_wdata == 8'd0) begin
                  len_in = LEN_W'(1);
               end else if (32'(len_wdata) > PATTERN_MAX) begin
                  len_in = LEN_W'(PATTERN_MAX);
               end else begin
                  len_in = LEN_W'(len_wdata);
               end
            end
            default: begin
               // Writes beyond the register list are dropped.
            end
         endcase
      end
   end

   // A stream byte is only looked at while the scan is still open. Once the
   // position counter has saturated, bytes are no longer compared, but a
   // last-byte mark still closes the scan with a not-found word.
   assign stream_item = s1_valid_ff && (s1_op_ff == mbps_pkg::OP_STREAM) && !done_ff;
   assign saturated   = (pos_ff == {POS_W{1'b1}});
   assign taken       = pos_ff + POS_W'(1);
   assign len_wide    = POS_W'(len_ff);
   assign start_pos   = taken - len_wide;

   assign hit       = stream_item && !saturated && (taken >= len_wide) &&
                      (start_pos >= start_ff) && window_match;
   assign not_found = stream_item && !hit && s1_last_ff;
   assign produce   = hit || not_found;

   // The held word moves on when it makes no response word or when the
   // response register is empty or being emptied in this cycle.
   assign out_free       = !out_valid_ff || rsp_ch.ready;
   assign advance        = s1_valid_ff && (out_free || !produce);
   assign req_ch.ready   = !s1_valid_ff || advance;
   assign req_accept     = req_ch.valid && req_ch.ready;

   assign ctl.load         = advance && (s1_op_ff == mbps_pkg::OP_LOAD) &&
                             (32'(s1_idx_ff) < PATTERN_MAX);
   assign ctl.shift        = advance && stream_item;
   assign ctl.restart      = advance && (s1_op_ff == mbps_pkg::OP_RESTART);
   assign ctl.entry_index  = s1_idx_ff;
   assign ctl.pattern_byte = s1_pbyte_ff;
   assign ctl.care         = s1_care_ff;
   assign ctl.data_byte    = s1_data_ff;

   mbps_match #(
      .PATTERN_MAX (PATTERN_MAX),
      .LEN_W       (LEN_W)
   ) u_match (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .pattern_len (len_ff),
      .match       (window_match)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_op_in    = s1_op_ff;
      s1_idx_in   = s1_idx_ff;
      s1_pbyte_in = s1_pbyte_ff;
      s1_care_in  = s1_care_ff;
      s1_data_in  = s1_data_ff;
      s1_last_in  = s1_last_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_op_in    = req_ch.opcode;
         s1_idx_in   = req_ch.entry_index;
         s1_pbyte_in = req_ch.pattern_byte;
         s1_care_in  = req_ch.care;
         s1_data_in  = req_ch.data_byte;
         s1_last_in  = req_ch.last_byte;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      pos_in  = pos_ff;
      done_in = done_ff;
      if (ctl.restart) begin
         pos_in  = '0;
         done_in = 1'b0;
      end else if (ctl.shift) begin
         if (!saturated) begin
            pos_in = taken;
         end
         if (produce) begin
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_found_in  = out_found_ff;
      out_offset_in = out_offset_ff;
      out_addr_in   = out_addr_ff;
      if (advance && produce) begin
         out_valid_in = 1'b1;
         out_found_in = hit;
         if (hit) begin
            out_offset_in = start_pos;
            out_addr_in   = base_ff + mbps_pkg::ADDR_W'(start_pos);
         end else begin
            out_offset_in = '0;
            out_addr_in   = '0;
         end
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         start_ff     <= '0;
         len_ff       <= LEN_W'(1);
         s1_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         done_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         start_ff     <= start_in;
         len_ff       <= len_in;
         s1_valid_ff  <= s1_valid_in;
         pos_ff       <= pos_in;
         done_ff      <= done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      s1_op_ff      <= s1_op_in;
      s1_idx_ff     <= s1_idx_in;
      s1_pbyte_ff   <= s1_pbyte_in;
      s1_care_ff    <= s1_care_in;
      s1_data_ff    <= s1_data_in;
      s1_last_ff    <= s1_last_in;
      out_found_ff  <= out_found_in;
      out_offset_ff <= out_offset_in;
      out_addr_ff   <= out_addr_in;
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.found         = out_found_ff;
   assign rsp_ch.match_offset  = out_offset_ff;
   assign rsp_ch.match_address = out_addr_ff;

endmodule

// ----- design/mbps_match.sv -----
module mbps_match #(
   parameter int unsigned PATTERN_MAX = 128,
   parameter int unsigned LEN_W       = $clog2(PATTERN_MAX + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  mbps_pkg::ctl_type ctl,
   input  logic [LEN_W-1:0]  pattern_len,
   output logic              match
);

   localparam int unsigned IDX_W = $clog2(PATTERN_MAX);

   logic [PATTERN_MAX*8-1:0] value_ff, value_in;
   logic [PATTERN_MAX-1:0]   care_ff, care_in;
   logic [PATTERN_MAX*8-1:0] window_ff, window_in, window_shifted;

   logic [PATTERN_MAX*8-1:0] value_rev, value_aligned;
   logic [PATTERN_MAX-1:0]   care_rev, care_aligned;
   logic [PATTERN_MAX-1:0]   mismatch;
   logic [IDX_W-1:0]         load_idx;
   logic [IDX_W-1:0]         align_shift;

   assign load_idx = IDX_W'(ctl.entry_index);

   // Window slot w holds pattern entry len-1-w, so the reversed pattern is
   // shifted down by PATTERN_MAX-len; unused slots receive care 0.
   assign align_shift = IDX_W'(LEN_W'(PATTERN_MAX) - pattern_len);

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_rev
      assign value_rev[(PATTERN_MAX-1-j)*8 +: 8] = value_ff[j*8 +: 8];
      assign care_rev[PATTERN_MAX-1-j]           = care_ff[j];
   end

   assign value_aligned  = value_rev >> {align_shift, 3'b000};
   assign care_aligned   = care_rev >> align_shift;
   assign window_shifted = {window_ff[PATTERN_MAX*8-9:0], ctl.data_byte};

   always_comb begin
      for (int w = 0; w < PATTERN_MAX; w++) begin
         mismatch[w] = care_aligned[w] &&
                       (window_shifted[w*8 +: 8] != value_aligned[w*8 +: 8]);
      end
   end

   assign match = ~|mismatch;

   always_comb begin
      value_in  = value_ff;
      care_in   = care_ff;
      window_in = window_ff;
      if (ctl.load) begin
         value_in[load_idx*8 +: 8] = ctl.pattern_byte;
         care_in[load_idx]         = ctl.care;
      end
      if (ctl.restart) begin
         window_in = '0;
      end else if (ctl.shift) begin
         window_in = window_shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff  <= '0;
         care_ff   <= '0;
         window_ff <= '0;
      end else begin
         value_ff  <= value_in;
         care_ff   <= care_in;
         window_ff <= window_in;
      end
   end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

   localparam int unsigned PATTERN_MAX = 128;
   localparam int          STALL_LIMIT = 4000;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          PHASE_WORDS = 500;
   localparam int          SEGMENT_WORDS = 120;

   // Opcode 3 and register index 3 have no meaning in the block; both must be ignored.
   localparam logic [1:0] OP_UNKNOWN = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam logic [31:0] POSITION_MAX = 32'hFFFF_FFFF;

   typedef struct {
      logic [1:0] opcode;
      logic [6:0] entry_index;
      logic [7:0] pattern_byte;
      logic       care;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic        found;
      logic [31:0] offset;
      logic [63:0] address;
   } hit_type;

   // The scoreboard keeps its own copy of the pattern, the byte window, the scan
   // position and the registers, and predicts the response word (if any) that each
   // accepted request word causes.
   class match_tracker_type;
      logic [7:0]  pat_val  [PATTERN_MAX];
      logic        pat_care [PATTERN_MAX];
      logic [7:0]  window   [PATTERN_MAX];
      logic [31:0] position;
      logic        done;
      logic [63:0] base_address;
      logic [31:0] start_offset;
      logic [7:0]  pattern_len;
      hit_type     expected_hits[$];
      int          errors;

      function new();
         for (int i = 0; i < PATTERN_MAX; i++) begin
            pat_val[i]  = 8'h00;
            pat_care[i] = 1'b0;
            window[i]   = 8'h00;
         end
         position     = '0;
         done         = 1'b0;
         base_address = '0;
         start_offset = '0;
         pattern_len  = 8'd1;
         errors       = 0;
      endfunction

      function int active_len();
         if (pattern_len == 0)
            return 1;
         if (pattern_len > PATTERN_MAX)
            return PATTERN_MAX;
         return pattern_len;
      endfunction

      function int pending();
         return expected_hits.size();
      endfunction

      function void write_reg(logic [1:0] idx, logic [63:0] value);
         if (idx == mbps_pkg::CSR_BASE_ADDRESS)
            base_address = value;
         else if (idx == mbps_pkg::CSR_START_OFFSET)
            start_offset = value[31:0];
         else if (idx == mbps_pkg::CSR_PATTERN_LEN)
            pattern_len = value[7:0];
      endfunction

      // Run byte j of a len-byte run sits in window slot len-1-j (slot 0 is newest).
      function bit window_matches(int len);
         for (int j = 0; j < len; j++) begin
            if (pat_care[j] && window[len - 1 - j] != pat_val[j])
               return 1'b0;
         end
         return 1'b1;
      endfunction

      // Returns 1 when the word changes state or gives a result, 0 when it is ignored.
      function bit note_word(req_word_type w);
         logic [31:0] len32;
         logic [31:0] start_pos;
         if (w.opcode == mbps_pkg::OP_LOAD) begin
            if (w.entry_index < PATTERN_MAX) begin
               pat_val[w.entry_index]  = w.pattern_byte;
               pat_care[w.entry_index] = w.care;
            end
            return 1'b1;
         end
         if (w.opcode == mbps_pkg::OP_RESTART) begin
            for (int i = 0; i < PATTERN_MAX; i++)
               window[i] = 8'h00;
            position = '0;
            done     = 1'b0;
            return 1'b1;
         end
         if (w.opcode != mbps_pkg::OP_STREAM || done)
            return 1'b0;

         for (int i = PATTERN_MAX - 1; i > 0; i--)
            window[i] = window[i - 1];
         window[0] = w.data_byte;
         len32 = active_len();

         // A saturated position means the byte is shifted in but never compared.
         if (position != POSITION_MAX) begin
            position++;
            if (position >= len32) begin
               start_pos = position - len32;
               if (start_pos >= start_offset && window_matches(len32)) begin
                  done = 1'b1;
                  expected_hits.push_back('{1'b1, start_pos,
                                            base_address + {32'd0, start_pos}});
                  return 1'b1;
               end
            end
         end
         if (w.last_byte) begin
            done = 1'b1;
            expected_hits.push_back('{1'b0, 32'd0, 64'd0});
         end
         return 1'b1;
      endfunction

      task report(string msg);
         $display("mismatch @%0t: %s", $time, msg);
         errors++;
      endtask

      task check_result(logic found, logic [31:0] offset, logic [63:0] address);
         hit_type want;
         if (expected_hits.size() == 0) begin
            report($sformatf("response word with nothing expected (found=%0b off=%0h)",
                             found, offset));
            return;
         end
         want = expected_hits.pop_front();
         if (found !== want.found)
            report($sformatf("found %0b, expected %0b", found, want.found));
         if (offset !== want.offset)
            report($sformatf("match_offset %0h, expected %0h", offset, want.offset));
         if (address !== want.address)
            report($sformatf("match_address %0h, expected %0h", address, want.address));
      endtask
   endclass

   logic clock;
   logic reset;

   mbps_req_if req_bus ();
   mbps_rsp_if rsp_bus ();
   mbps_csr_if csr_bus ();

   match_tracker_type tracker = new();

   int send_idle_pct;
   int rcv_idle_pct;
   int words_counted;
   int stall_cycles;

   masked_byte_pattern_search_core #(
      .PATTERN_MAX(PATTERN_MAX)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // 2 ns clock: one delay for the high half, one for the low half.
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The response side stalls at random; the stall rate follows the current phase.
   always @(negedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(99) >= rcv_idle_pct);
   end

   // Response words are taken at the rising edge and checked against the oldest
   // prediction.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_result(rsp_bus.found, rsp_bus.match_offset, rsp_bus.match_address);
   end

   // The watchdog counts cycles in which no channel moves a word. A hung block or a
   // lost response word ends the run here.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         stall_cycles = 0;
      else
         stall_cycles = stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Every task below is entered just after a falling edge and returns just after
   // one, so inputs only ever change at the falling edge.
   task automatic send_word(req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= w.opcode;
      req_bus.entry_index  <= w.entry_index;
      req_bus.pattern_byte <= w.pattern_byte;
      req_bus.care         <= w.care;
      req_bus.data_byte    <= w.data_byte;
      req_bus.last_byte    <= w.last_byte;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      // Only words that do something count toward the stimulus size.
      if (tracker.note_word(w))
         words_counted++;
      @(negedge clock);
   endtask

   task automatic send_load(int idx, logic [7:0] value, logic care);
      req_word_type w;
      w = '{mbps_pkg::OP_LOAD, idx[6:0], value, care, 8'($urandom_range(255)),
            1'($urandom_range(1))};
      send_word(w);
   endtask

   task automatic send_byte(logic [7:0] value, logic last);
      req_word_type w;
      w = '{mbps_pkg::OP_STREAM, 7'($urandom_range(127)), 8'($urandom_range(255)),
            1'($urandom_range(1)), value, last};
      send_word(w);
   endtask

   task automatic send_op(logic [1:0] op);
      req_word_type w;
      w = '{op, 7'($urandom_range(127)), 8'($urandom_range(255)), 1'($urandom_range(1)),
            8'($urandom_range(255)), 1'($urandom_range(1))};
      send_word(w);
   endtask

   // Registers are written only while the block is idle: every predicted response
   // word has arrived and the last request word has drained through the pipeline.
   task automatic wait_idle();
      while (tracker.pending() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [63:0] value);
      req_bus.valid <= 1'b0;
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= value;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      tracker.write_reg(idx, value);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   // A fresh register setting; extremes are picked often, but mostly the pattern
   // is short and the start offset small so that most scans end in a match.
   task automatic pick_config();
      int sel;
      sel = $urandom_range(3);
      case (sel)
         0: csr_write(mbps_pkg::CSR_BASE_ADDRESS, 64'd0);
         1: csr_write(mbps_pkg::CSR_BASE_ADDRESS, {64{1'b1}});
         default: csr_write(mbps_pkg::CSR_BASE_ADDRESS, {$urandom, $urandom});
      endcase
      sel = $urandom_range(9);
      case (sel)
         0: csr_write(mbps_pkg::CSR_START_OFFSET, {$urandom, 32'hFFFF_FFFF});
         1: csr_write(mbps_pkg::CSR_START_OFFSET, {$urandom, $urandom});
         2: csr_write(mbps_pkg::CSR_START_OFFSET, 64'd0);
         default: csr_write(mbps_pkg::CSR_START_OFFSET, 64'($urandom_range(12)));
      endcase
      sel = $urandom_range(13);
      case (sel)
         0: csr_write(mbps_pkg::CSR_PATTERN_LEN, {$urandom, 24'd0, 8'd0});
         1: csr_write(mbps_pkg::CSR_PATTERN_LEN, 64'd128);
         2: csr_write(mbps_pkg::CSR_PATTERN_LEN, {$urandom, 24'd0, 8'd255});
         3: csr_write(mbps_pkg::CSR_PATTERN_LEN, 64'($urandom_range(129, 254)));
         4: csr_write(mbps_pkg::CSR_PATTERN_LEN, 64'($urandom_range(11, 127)));
         default: csr_write(mbps_pkg::CSR_PATTERN_LEN, {$urandom, $urandom_range(1, 10)});
      endcase
      if ($urandom_range(7) == 0)
         csr_write(CSR_UNUSED, {$urandom, $urandom});
   endtask

   // One scan: usually a restart, a few pattern loads, then a stream that often
   // carries a copy of the pattern past the start offset. Filler bytes are often
   // taken from the pattern itself so that near misses are common. A little noise
   // (loads in mid-stream, unknown opcodes, early last marks) is mixed in.
   task automatic run_scan();
      int len;
      int plant_at;
      int n;
      int sel;
      bit plant;
      logic [7:0] stream_bytes[$];
      logic [7:0] b;

      if ($urandom_range(19) != 0)
         send_op(mbps_pkg::OP_RESTART);
      len = tracker.active_len();
      repeat ($urandom_range(0, 4)) begin
         if ($urandom_range(9) == 0)
            send_load($urandom_range(127), 8'($urandom_range(255)),
                      $urandom_range(3) != 0);
         else
            send_load($urandom_range(len - 1), 8'($urandom_range(255)),
                      $urandom_range(3) != 0);
      end

      plant = ($urandom_range(9) < 7) && (tracker.start_offset < 40);
      if (plant) begin
         plant_at = tracker.start_offset + $urandom_range(0, 6);
         n = plant_at + len + $urandom_range(0, 4);
      end else begin
         plant_at = -1;
         n = $urandom_range(1, (len < 24 ? len : 24) + 8);
      end
      for (int i = 0; i < n; i++) begin
         if (plant && i >= plant_at && i < plant_at + len) begin
            if (tracker.pat_care[i - plant_at])
               b = tracker.pat_val[i - plant_at];
            else
               b = 8'($urandom_range(255));
         end else if ($urandom_range(1) == 0) begin
            b = tracker.pat_val[$urandom_range(len - 1)];
         end else begin
            b = 8'($urandom_range(255));
         end
         stream_bytes.push_back(b);
      end

      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 4)
            send_load($urandom_range(len - 1), 8'($urandom_range(255)),
                      1'($urandom_range(1)));
         else if (sel < 6)
            send_op(OP_UNKNOWN);
         send_byte(stream_bytes[i], (i == n - 1) || ($urandom_range(99) < 2));
      end
   endtask

   initial begin
      // Every input of the block is known from time zero.
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.opcode       = mbps_pkg::OP_LOAD;
      req_bus.entry_index  = '0;
      req_bus.pattern_byte = '0;
      req_bus.care         = 1'b0;
      req_bus.data_byte    = '0;
      req_bus.last_byte    = 1'b0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = mbps_pkg::CSR_BASE_ADDRESS;
      csr_bus.wdata        = '0;
      send_idle_pct        = 11;
      rcv_idle_pct         = 73;
      words_counted        = 0;
      stall_cycles         = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. After reset the pattern is one wildcard, so the first byte
      // matches at once; the byte after it is ignored because the scan is over.
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_op(OP_UNKNOWN);
      send_load(127, 8'hFF, 1'b1);
      send_load(0, 8'hA5, 1'b1);
      send_op(mbps_pkg::OP_RESTART);
      send_byte(8'h00, 1'b0);
      send_byte(8'hA5, 1'b0);
      // A stream that ends without a match gives a not-found word.
      send_op(mbps_pkg::OP_RESTART);
      send_byte(8'h5A, 1'b1);

      // Pattern length zero acts as one; the start offset holds the match back, and
      // the address wraps around past the top of the address space. The match
      // lands on the last byte and takes priority over not-found.
      wait_idle();
      csr_write(mbps_pkg::CSR_BASE_ADDRESS, {64{1'b1}});
      csr_write(mbps_pkg::CSR_START_OFFSET, 64'd3);
      csr_write(mbps_pkg::CSR_PATTERN_LEN, 64'd0);
      send_op(mbps_pkg::OP_RESTART);
      repeat (3) send_byte(8'hA5, 1'b0);
      send_byte(8'hA5, 1'b1);

      // The largest start offset can never be reached.
      wait_idle();
      csr_write(mbps_pkg::CSR_PATTERN_LEN, 64'd2);
      csr_write(mbps_pkg::CSR_START_OFFSET, 64'hFFFF_FFFF);
      send_load(1, 8'h00, 1'b0);
      send_op(mbps_pkg::OP_RESTART);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h77, 1'b1);

      // A write to the unused index changes nothing.
      wait_idle();
      csr_write(CSR_UNUSED, {64{1'b1}});
      csr_write(mbps_pkg::CSR_START_OFFSET, 64'd0);
      send_op(mbps_pkg::OP_RESTART);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h3C, 1'b1);

      // Random part in three phases: a slow receiver, then a slow sender, then no
      // idling at all. The registers get a new setting every segment.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 11;
               rcv_idle_pct  = 73;
            end
            1: begin
               send_idle_pct = 73;
               rcv_idle_pct  = 11;
            end
            default: begin
               send_idle_pct = 0;
               rcv_idle_pct  = 0;
            end
         endcase
         words_counted = 0;
         while (words_counted < PHASE_WORDS) begin
            wait_idle();
            // A pattern length above the maximum acts as the maximum.
            if (phase == 2 && words_counted == 0)
               csr_write(mbps_pkg::CSR_PATTERN_LEN, 64'd255);
            else
               pick_config();
            while (words_counted % SEGMENT_WORDS < SEGMENT_WORDS - 20 &&
                   words_counted < PHASE_WORDS)
               run_scan();
            run_scan();
         end
      end

      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
